/* sv/dmct_pkg.sv */
package dmct_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_TABLE_SLOTS = 16384;
  localparam int DEF_COUNT_BITS  = 16;

  // Fixed field widths
  localparam int ACTION_W    = 2;
  localparam int KEY_W       = 64;
  localparam int COUNT_OUT_W = 16;
  localparam int TOTAL_W     = 32;

  // Slot reduction: key bits consumed per iteration, and iterations per key
  localparam int REDUCE_BITS  = 4;
  localparam int REDUCE_STEPS = KEY_W / REDUCE_BITS;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic reduce_step;
    logic read;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic index_ready;
    logic out_free;
  } status_t;

endpackage

/* sv/dmct_ram.sv */
module dmct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold the last word when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dmct_ctrl.sv */
module dmct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dmct_pkg::status_t status,
  output dmct_pkg::cmd_t    cmd
);

  import dmct_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (status.index_ready) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      ST_INDEX: begin
        cmd.read        = status.index_ready;
        cmd.reduce_step = !status.index_ready;
      end
      ST_UPDATE: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/dmct_datapath.sv */
module dmct_datapath #(
  parameter int TABLE_SLOTS = dmct_pkg::DEF_TABLE_SLOTS,
  parameter int COUNT_BITS  = dmct_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dmct_pkg::cmd_t                   cmd,
  output dmct_pkg::status_t                status,
  input  logic [dmct_pkg::ACTION_W-1:0]    action,
  input  logic [dmct_pkg::KEY_W-1:0]       key,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [dmct_pkg::COUNT_OUT_W-1:0] count,
  output logic                             collided,
  output logic [dmct_pkg::TOTAL_W-1:0]     collision_total
);

  import dmct_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = KEY_W + COUNT_BITS;
  localparam int RCNT_W  = $clog2(REDUCE_STEPS + 1);
  localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam logic [IDX_W:0]        SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0]      LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [RCNT_W-1:0]     RCNT_INIT = IS_POW2 ? '0 : RCNT_W'(REDUCE_STEPS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Held transaction
  logic [ACTION_W-1:0] act;
  logic [KEY_W-1:0]    key_hold;
  logic [KEY_W-1:0]    kshift;
  logic [IDX_W-1:0]    slot;
  logic [RCNT_W-1:0]   rcnt;

  logic [IDX_W-1:0]    slot_red;
  logic [IDX_W:0]      trial;

  logic [IDX_W-1:0]    clr_addr;
  logic [TOTAL_W-1:0]  coll_total;

  logic [ENTRY_W-1:0]    rdata;
  logic [KEY_W-1:0]      stored;
  logic [COUNT_BITS-1:0] cnt;
  logic                  hit;
  logic                  empty;

  logic                  upd_we;
  logic [KEY_W-1:0]      wkey;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] res;
  logic                  coll;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;

  // Capture the transaction and step the slot reduction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= action;
      key_hold <= key;
      kshift   <= key;
      slot     <= IS_POW2 ? key[IDX_W-1:0] : '0;
    end else if (cmd.reduce_step) begin
      kshift <= kshift << REDUCE_BITS;
      slot   <= slot_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (cmd.load) begin
      rcnt <= RCNT_INIT;
    end else if (cmd.reduce_step) begin
      rcnt <= rcnt - RCNT_W'(1);
    end
  end

  // Fold the next key bits into the running remainder, one compare and subtract each
  always_comb begin
    slot_red = slot;
    trial    = '0;
    for (int j = 0; j < REDUCE_BITS; j++) begin
      trial = {slot_red, kshift[KEY_W-1-j]};
      if (trial >= SLOTS_EXT) begin
        trial = trial - SLOTS_EXT;
      end
      slot_red = trial[IDX_W-1:0];
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Decode the slot entry and work out the update
  assign stored = rdata[ENTRY_W-1:COUNT_BITS];
  assign cnt    = rdata[COUNT_BITS-1:0];
  assign hit    = (stored == key_hold);
  assign empty  = (stored == '0);

  always_comb begin
    upd_we  = 1'b0;
    wkey    = key_hold;
    cnt_new = cnt;
    res     = '0;
    coll    = 1'b0;
    case (act)
      ACT_ADD: begin
        if (hit || empty) begin
          cnt_new = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
          upd_we  = 1'b1;
          res     = cnt_new;
        end else begin
          coll = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          cnt_new = (cnt == '0) ? cnt : cnt - COUNT_BITS'(1);
          wkey    = (cnt_new == '0) ? '0 : key_hold;
          upd_we  = 1'b1;
          res     = cnt_new;
        end else begin
          coll = 1'b1;
        end
      end
      ACT_GET: begin
        if (hit) begin
          res = cnt;
        end else if (!empty) begin
          coll = 1'b1;
        end
      end
      default: begin
        coll = 1'b0;
      end
    endcase
  end

  // Table write port: clearing sweep or committed update
  assign ram_we    = cmd.clr_step || (cmd.commit && upd_we);
  assign ram_waddr = cmd.clr_step ? clr_addr : slot;
  assign ram_wdata = cmd.clr_step ? '0 : {wkey, cnt_new};

  dmct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (slot),
    .rdata (rdata)
  );

  // Collision counter, wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      coll_total <= '0;
    end else if (cmd.commit) begin
      coll_total <= coll_total + TOTAL_W'(coll);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      count           <= COUNT_OUT_W'(res);
      collided        <= coll;
      collision_total <= coll_total + TOTAL_W'(coll);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Status
  assign status.clear_last  = (clr_addr == LAST_SLOT);
  assign status.index_ready = (rcnt == '0);
  assign status.out_free    = !result_valid || !result_stall;

endmodule

/* sv/direct_mapped_count_table_top.sv */
// Direct-mapped table of 64-bit keys with saturating occurrence counts. Each
// transaction (action, key) yields exactly one result. After reset the table
// is cleared by a sweep over all TABLE_SLOTS slots, one slot per cycle, during
// which item_stall stays high. An item then goes through capture, table read on
// the registered-read memory, then the read-modify-write and result load. When
// TABLE_SLOTS is not a power of two the slot index is the key modulo
// TABLE_SLOTS, reduced 4 key bits a cycle between capture and table read.
// One item is in flight at a time; a finished result may wait in the output
// register while the next item is taken and looked up.
module direct_mapped_count_table_top #(
  parameter int TABLE_SLOTS = dmct_pkg::DEF_TABLE_SLOTS,
  parameter int COUNT_BITS  = dmct_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [dmct_pkg::ACTION_W-1:0]    action,
  input  logic [dmct_pkg::KEY_W-1:0]       key,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [dmct_pkg::COUNT_OUT_W-1:0] count,
  output logic                             collided,
  output logic [dmct_pkg::TOTAL_W-1:0]     collision_total
);

  import dmct_pkg::*;

  cmd_t    cmd;
  status_t status;

  dmct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  dmct_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (action),
    .key             (key),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .count           (count),
    .collided        (collided),
    .collision_total (collision_total)
  );

`ifndef SYNTH
  // No transaction is taken while the table is being cleared
  assert property (@(posedge clk) disable iff (rst) cmd.clr_step |-> item_stall)
    else $error("item accepted during clearing sweep");

  // A committed update always shows up as a pending result
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> result_valid)
    else $error("commit did not load the result register");

  // A collision never reports a count
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && collided) |-> (count == '0))
    else $error("collision reported with nonzero count");

  // After an accepted item the block is busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second item accepted while one is in flight");
`endif

endmodule

/* verif/direct_mapped_count_table_top_test.sv */
`timescale 1ns / 100ps

module direct_mapped_count_table_top_test;
  import dmct_pkg::*;

  // Narrow counts so that saturation is reached within a few hundred adds
  localparam int SLOTS      = DEF_TABLE_SLOTS;
  localparam int CNT_BITS   = 8;
  localparam int IDLE_LIMIT = 50000;
  localparam int HOLD_LEN   = 120;
  localparam int RAND_ITEMS = 1566;
  localparam int POOL_SIZE  = 16;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    bit                  calm;
  } lookup_t;

  typedef struct {
    logic [COUNT_OUT_W-1:0] count;
    logic                   collided;
    logic [TOTAL_W-1:0]     total;
  } tally_t;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic [ACTION_W-1:0]    action;
  logic [KEY_W-1:0]       key;
  logic                   result_valid;
  logic                   result_stall;
  logic [COUNT_OUT_W-1:0] count;
  logic                   collided;
  logic [TOTAL_W-1:0]     collision_total;

  // Mirror of the table contents
  bit [KEY_W-1:0]    mirror_keys [SLOTS];
  bit [CNT_BITS-1:0] mirror_counts [SLOTS];
  bit [TOTAL_W-1:0]  mirror_collisions;

  lookup_t pending_lookups[$];
  tally_t  tally_q[$];
  int      accepted_items;
  int      sent_items;
  int      results_seen;
  int      total_items;
  int      squeeze_at;
  int      quiet_cycles;
  int      mismatch_count;
  int      hold_left;
  bit      squeezed;
  bit      calm;

  direct_mapped_count_table_top #(
    .TABLE_SLOTS (SLOTS),
    .COUNT_BITS  (CNT_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .action          (action),
    .key             (key),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .count           (count),
    .collided        (collided),
    .collision_total (collision_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one transaction to the mirror and return the result it yields
  function automatic tally_t tally_apply(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k);
    int unsigned       idx;
    bit [KEY_W-1:0]    held;
    bit [CNT_BITS-1:0] cnt;
    bit                hit;
    bit                vacant;
    tally_t            r;
    idx    = int'(k % 64'(SLOTS));
    held   = mirror_keys[idx];
    cnt    = mirror_counts[idx];
    hit    = (held == k);
    vacant = (held == '0);
    r.count    = '0;
    r.collided = 1'b0;
    case (act)
      ACT_ADD: begin
        if (hit || vacant) begin
          if (cnt != '1) cnt++;
          mirror_keys[idx]   = k;
          mirror_counts[idx] = cnt;
          r.count = COUNT_OUT_W'(cnt);
        end else begin
          r.collided = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          if (cnt != '0) cnt--;
          mirror_counts[idx] = cnt;
          if (cnt == '0) mirror_keys[idx] = '0;
          r.count = COUNT_OUT_W'(cnt);
        end else begin
          r.collided = 1'b1;
        end
      end
      ACT_GET: begin
        if (hit) r.count = COUNT_OUT_W'(cnt);
        else if (!vacant) r.collided = 1'b1;
      end
      default: ;
    endcase
    if (r.collided) mirror_collisions++;
    r.total = mirror_collisions;
    return r;
  endfunction

  function automatic void queue_lookup(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] k,
                                       bit quiet = 1'b0);
    lookup_t item;
    item.act  = act;
    item.key  = k;
    item.calm = quiet;
    pending_lookups.push_back(item);
  endfunction

  // Drive transactions from the pending queue, with random gaps before items not marked calm
  always @(negedge clk) begin : drive_lookups
    bit held;
    if (!rst) begin
      held = item_valid;
      if (held && accepted_items != sent_items) begin
        void'(pending_lookups.pop_front());
        sent_items++;
        held = 1'b0;
      end
      if (!held) begin
        if (pending_lookups.size() != 0 &&
            (pending_lookups[0].calm || $urandom_range(99) >= 37)) begin
          item_valid <= 1'b1;
          action     <= pending_lookups[0].act;
          key        <= pending_lookups[0].key;
          calm       <= pending_lookups[0].calm;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Stall results at random, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!squeezed && results_seen >= squeeze_at) begin
      squeezed     <= 1'b1;
      hold_left    <= HOLD_LEN;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 37);
    end
  end

  // Record accepted transactions, check results, and watch for a hang
  always @(posedge clk) begin : watch_results
    tally_t want;
    bit     moved;
    if (!rst) begin
      moved = 1'b0;
      if (item_valid && !item_stall) begin
        tally_q.push_back(tally_apply(action, key));
        accepted_items++;
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        moved = 1'b1;
        if (tally_q.size() == 0) begin
          $display("%0t: unexpected result count %0d collided %0d total %0d",
                   $time, count, collided, collision_total);
          mismatch_count++;
        end else begin
          want = tally_q.pop_front();
          if (count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, count);
            mismatch_count++;
          end
          if (collided !== want.collided) begin
            $display("%0t: collided expected %0d actual %0d", $time, want.collided, collided);
            mismatch_count++;
          end
          if (collision_total !== want.total) begin
            $display("%0t: collision_total expected %0d actual %0d",
                     $time, want.total, collision_total);
            mismatch_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("direct_mapped_count_table_top_test: errors");
        $finish;
      end
    end
  end

  initial begin : run_test
    logic [KEY_W-1:0]  key_a;
    logic [KEY_W-1:0]  sat_key;
    logic [KEY_W-1:0]  pool [POOL_SIZE];
    logic [13:0]       slot_set [6];
    logic [KEY_W-1:0]  k;
    logic [ACTION_W-1:0] a;
    int                pick;

    clk            = 1'b0;
    rst            = 1'b1;
    item_valid     = 1'b0;
    action         = ACT_ADD;
    key            = '0;
    result_stall   = 1'b0;
    calm           = 1'b0;
    squeezed       = 1'b0;
    hold_left      = 0;
    accepted_items = 0;
    sent_items     = 0;
    results_seen   = 0;
    quiet_cycles   = 0;
    mismatch_count = 0;
    mirror_collisions = '0;

    // Directed: empty get, hits, a collision, freeing a slot
    key_a = 64'h0123_4567_89AB_C005;
    queue_lookup(ACT_GET, key_a);
    queue_lookup(ACT_ADD, key_a);
    queue_lookup(ACT_ADD, key_a);
    queue_lookup(ACT_GET, key_a);
    queue_lookup(ACT_ADD, key_a ^ 64'h4000);
    queue_lookup(ACT_GET, key_a ^ 64'h4000);
    queue_lookup(ACT_REMOVE, key_a ^ 64'h4000);
    queue_lookup(ACT_REMOVE, key_a);
    queue_lookup(ACT_REMOVE, key_a);
    queue_lookup(ACT_GET, key_a);
    // Key zero on an empty slot: remove at zero, then count up while still empty
    queue_lookup(ACT_REMOVE, '0);
    queue_lookup(ACT_ADD, '0);
    queue_lookup(ACT_ADD, '0);
    queue_lookup(ACT_ADD, 64'h4000);
    queue_lookup(ACT_GET, '0);
    queue_lookup(ACT_REMOVE, 64'h4000);
    queue_lookup(ACT_REMOVE, 64'h4000);
    queue_lookup(ACT_REMOVE, 64'h4000);
    // Extremes of the key and the unused action
    queue_lookup(ACT_ADD, '1);
    queue_lookup(ACT_GET, '1);
    queue_lookup(ACT_UNUSED, '1);
    queue_lookup(ACT_UNUSED, '0);
    queue_lookup(ACT_ADD, 64'h8000_0000_0000_0000);
    queue_lookup(ACT_GET, 64'h8000_0000_0000_0000);

    // Saturate one slot, with no gaps on either side
    sat_key = 64'hFEDC_BA98_7654_3FFF;
    for (int i = 0; i < (1 << CNT_BITS) + 2; i++) queue_lookup(ACT_ADD, sat_key, 1'b1);
    queue_lookup(ACT_GET, sat_key, 1'b1);
    queue_lookup(ACT_REMOVE, sat_key, 1'b1);

    // Random: mostly a small pool of keys crowded onto a few slots
    foreach (slot_set[i]) slot_set[i] = 14'($urandom);
    foreach (pool[i]) pool[i] = {$urandom, 18'($urandom), slot_set[$urandom_range(5)]};
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 75)      k = pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 90) k = {$urandom, $urandom};
      else if (pick < 95) k = '0;
      else                k = {$urandom, 18'($urandom), slot_set[$urandom_range(5)]};
      pick = $urandom_range(99);
      if (pick < 45)      a = ACT_ADD;
      else if (pick < 70) a = ACT_REMOVE;
      else if (pick < 95) a = ACT_GET;
      else                a = ACT_UNUSED;
      queue_lookup(a, k);
    end
    total_items = pending_lookups.size();
    squeeze_at  = total_items - 1000;

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every transaction and result, then let the pipeline settle
    while (!(sent_items == total_items && tally_q.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tally_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, tally_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("direct_mapped_count_table_top_test: clean");
    end else begin
      $display("direct_mapped_count_table_top_test: errors");
    end
    $finish;
  end

endmodule
